@@ hdl/rpd_pkg.sv @@
`default_nettype none
package rpd_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] START_MARK = 8'h24;
	localparam logic [7:0] END_MARK   = 8'h23;
	localparam logic [7:0] ACK_GOOD   = 8'h2B;
	localparam logic [7:0] ACK_BAD    = 8'h2D;

	localparam logic [2:0] REG_ADDR_NO_ACK = 3'd0;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_BODY = 2'd1,
		PH_CKHI = 2'd2,
		PH_CKLO = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_CHECK = 2'd2
	} op_code_t;

	typedef struct packed {
		op_code_t   code;
		logic [7:0] value;
	} op_t;

endpackage
`default_nettype wire

@@ hdl/rpd_front.sv @@
`default_nettype none
module rpd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [7:0]   in_byte,
	output logic              in_ready,
	output logic              push_valid,
	output rpd_pkg::op_t      push_op,
	input  wire logic         push_ready
);

	rpd_pkg::phase_t phase_q, phase_d;
	logic [3:0] nibble_q, nibble_d;
	logic       accept;
	logic [3:0] hex_nib;

	function automatic logic [3:0] hex_value(input logic [7:0] ch);
		logic [3:0] v;
		v = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			v = ch[3:0];
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			v = 4'(ch[2:0] + 3'd1) + 4'd8;
		end
		return v;
	endfunction

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;
	assign hex_nib  = hex_value(in_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rpd_pkg::PH_HUNT;
			nibble_q <= 4'd0;
		end else begin
			phase_q  <= phase_d;
			nibble_q <= nibble_d;
		end
	end

	always_comb begin
		phase_d          = phase_q;
		nibble_d         = nibble_q;
		push_valid       = 1'b0;
		push_op.code     = rpd_pkg::OP_DATA;
		push_op.value    = in_byte;
		if (accept) begin
			unique case (phase_q)
				rpd_pkg::PH_HUNT: begin
					if (in_byte == rpd_pkg::START_MARK) begin
						phase_d      = rpd_pkg::PH_BODY;
						push_valid   = 1'b1;
						push_op.code = rpd_pkg::OP_START;
					end
				end
				rpd_pkg::PH_BODY: begin
					if (in_byte == rpd_pkg::END_MARK) begin
						phase_d = rpd_pkg::PH_CKHI;
					end else begin
						push_valid = 1'b1;
					end
				end
				rpd_pkg::PH_CKHI: begin
					nibble_d = hex_nib;
					phase_d  = rpd_pkg::PH_CKLO;
				end
				rpd_pkg::PH_CKLO: begin
					push_valid    = 1'b1;
					push_op.code  = rpd_pkg::OP_CHECK;
					push_op.value = {nibble_q, hex_nib};
					nibble_d      = 4'd0;
					phase_d       = rpd_pkg::PH_HUNT;
				end
				default: begin
					phase_d = rpd_pkg::PH_HUNT;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/rpd_queue.sv @@
`default_nettype none
module rpd_queue #(
	parameter int unsigned DEPTH = rpd_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire rpd_pkg::op_t  push_op,
	output logic               push_ready,
	output logic               pop_valid,
	output rpd_pkg::op_t       pop_op,
	input  wire logic          pop_ready
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	rpd_pkg::op_t  slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/rpd_back.sv @@
`default_nettype none
module rpd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          no_ack_mode,
	input  wire logic          pop_valid,
	input  wire rpd_pkg::op_t  pop_op,
	output logic               pop_ready,
	output logic               out_valid,
	output rpd_pkg::kind_t     out_kind,
	output logic [7:0]         out_byte,
	output logic               send_ack,
	input  wire logic          out_ready
);

	logic [7:0]     sum_q;
	logic           valid_q;
	rpd_pkg::kind_t kind_q;
	logic [7:0]     byte_q;
	logic           ack_q;
	logic           do_pop;
	logic           good;

	assign pop_ready = !valid_q || out_ready;
	assign do_pop    = pop_valid && pop_ready;
	assign good      = (pop_op.value == sum_q);

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_byte  = byte_q;
	assign send_ack  = ack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= 8'd0;
			valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (do_pop) begin
				unique case (pop_op.code)
					rpd_pkg::OP_START: begin
						sum_q <= 8'd0;
					end
					rpd_pkg::OP_DATA: begin
						sum_q   <= sum_q + pop_op.value;
						valid_q <= 1'b1;
					end
					rpd_pkg::OP_CHECK: begin
						sum_q   <= 8'd0;
						valid_q <= 1'b1;
					end
					default: begin
						sum_q <= sum_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			if (pop_op.code == rpd_pkg::OP_CHECK) begin
				kind_q <= good ? rpd_pkg::KIND_GOOD : rpd_pkg::KIND_BAD;
				byte_q <= good ? rpd_pkg::ACK_GOOD : rpd_pkg::ACK_BAD;
				ack_q  <= !no_ack_mode;
			end else if (pop_op.code == rpd_pkg::OP_DATA) begin
				kind_q <= rpd_pkg::KIND_PAYLOAD;
				byte_q <= pop_op.value;
				ack_q  <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/rsp_packet_deframer_core.sv @@
// Packet deframer for a remote serial debug link. It takes one received byte per
// cycle on the slave stream, unless the master stream stalls, and gives payload
// bytes and one packet end word per packet on the master stream. The front tracks
// the framing phase and decodes the hex checksum, a two-entry queue follows, and the
// back keeps the modulo-256 sum and registers each result, so each byte passes
// through a queue slot and then the back's output register. Register 0 (address 0)
// holds no_ack_mode, which clears send_ack in packet end words.
`default_nettype none
module rsp_packet_deframer_core #(
	parameter int unsigned QUEUE_DEPTH = rpd_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // rx_byte[7:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // out_byte[7:0]
	output logic [2:0]       m_tuser,  // out_kind[1:0], send_ack[2]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic           no_ack_q;
	logic           push_valid, push_ready;
	rpd_pkg::op_t   push_op;
	logic           pop_valid, pop_ready;
	rpd_pkg::op_t   pop_op;
	rpd_pkg::kind_t out_kind;
	logic           send_ack;

	assign pready = 1'b1;
	assign prdata = (paddr == rpd_pkg::REG_ADDR_NO_ACK) ? {31'd0, no_ack_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_ack_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == rpd_pkg::REG_ADDR_NO_ACK) begin
			no_ack_q <= pwdata[0];
		end
	end

	rpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.in_ready   (s_tready),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	rpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	rpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.no_ack_mode (no_ack_q),
		.pop_valid   (pop_valid),
		.pop_op      (pop_op),
		.pop_ready   (pop_ready),
		.out_valid   (m_tvalid),
		.out_kind    (out_kind),
		.out_byte    (m_tdata),
		.send_ack    (send_ack),
		.out_ready   (m_tready)
	);

	assign m_tuser = {send_ack, out_kind};

`ifndef ASSERT_OFF
	a_payload_no_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1:0] == rpd_pkg::KIND_PAYLOAD) |-> !m_tuser[2])
		else $error("payload word carries send_ack");

	a_good_char: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1:0] == rpd_pkg::KIND_GOOD) |-> m_tdata == rpd_pkg::ACK_GOOD)
		else $error("good packet end without plus");

	a_bad_char: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1:0] == rpd_pkg::KIND_BAD) |-> m_tdata == rpd_pkg::ACK_BAD)
		else $error("bad packet end without minus");

	a_end_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1:0] != rpd_pkg::KIND_PAYLOAD) |-> m_tuser[2] == !no_ack_q)
		else $error("send_ack disagrees with no_ack_mode");
`endif

endmodule
`default_nettype wire
